FILE: design/ipsc_pkg.sv
`timescale 1ns / 1ps
// Package: shared types, codes and signature tables for the classifier.
package ipsc_pkg;

    localparam int HEAD_DEPTH = 17;

    typedef enum logic [1:0] {
        VERDICT_UNDECIDED = 2'd0,
        VERDICT_REAL      = 2'd1,
        VERDICT_CORREL    = 2'd2,
        VERDICT_EXCLUDED  = 2'd3
    } verdict_t;

    typedef enum logic {
        REG_SPECIAL_PORT = 1'b0,
        REG_GRACE        = 1'b1
    } reg_index_t;

    localparam logic [15:0] SPECIAL_PORT_RESET = 16'd9000;
    localparam logic [7:0]  GRACE_RESET        = 8'd5;

    // one input transaction
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_last;
        logic [15:0] payload_len;
        logic        is_tcp;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [2:0]  stage_in;
        logic [15:0] next_len_in;
        logic [7:0]  packets_seen;
        logic        http_excluded;
    } item_t;

    // snapshot of a finished packet, ready for rule evaluation
    typedef struct packed {
        logic [HEAD_DEPTH-1:0][7:0] head;
        logic [3:0][7:0]            tail;
        logic                       zero_short;
        logic                       zero_long;
        logic [15:0]                len;
        logic                       is_tcp;
        logic [15:0]                src_port;
        logic [15:0]                dst_port;
        logic [2:0]                 stage;
        logic [15:0]                next_len;
        logic [7:0]                 seen;
        logic                       http_excluded;
    } job_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [2:0]  stage;
        logic [15:0] next_len;
    } result_t;

    typedef struct packed {
        logic [15:0] special_port;
        logic [7:0]  grace;
    } cfg_t;

    localparam logic [45:0][15:0] KNOWN_VERSIONS = {
        16'h0100, 16'h05a5, 16'h062e, 16'h06d5, 16'h072e, 16'h0801, 16'h087d, 16'h08d2,
        16'h0961, 16'h0a1d, 16'h0b07, 16'h0b2f, 16'h0b35, 16'h0b37, 16'h0c0b, 16'h0c0d,
        16'h0c21, 16'h0c49, 16'h0d05, 16'h0d51, 16'h0d55, 16'h0d61, 16'h0e1b, 16'h0e35,
        16'h0f15, 16'h0f4b, 16'h0f5f, 16'h1105, 16'h111b, 16'h111d, 16'h1131, 16'h113f,
        16'h115b, 16'h1203, 16'h1205, 16'h120b, 16'h1251, 16'h1412, 16'h1441, 16'h1501,
        16'h1549, 16'h163a, 16'h1801, 16'h180d, 16'h1c27, 16'h1e0d
    };

    localparam logic [10:0][15:0] UDP_TAGS = {
        16'h1549, 16'h1801, 16'h180d, 16'h0961, 16'h1501, 16'h0e35, 16'h113f, 16'h0b37,
        16'h1131, 16'h163a, 16'h1e0d
    };

    localparam logic [11:0][15:0] KNOWN_CMDS = {
        16'h0091, 16'h00ba, 16'h00dd, 16'h00e5, 16'h00a4, 16'h0030, 16'h001d, 16'h0001,
        16'h0062, 16'h0002, 16'h0022, 16'h0029
    };

    // element 13 holds the first character
    localparam logic [13:0][7:0] GET_PREFIX = "GET /qqfile/qq";

endpackage

FILE: design/ipsc_if.sv
`timescale 1ns / 1ps
// Interfaces: input byte channel and result channel.
interface ipsc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        byte_last;
    logic [15:0] payload_len;
    logic        is_tcp;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [2:0]  stage_in;
    logic [15:0] next_len_in;
    logic [7:0]  packets_seen;
    logic        http_excluded;

    modport source (
        output valid, data_byte, byte_last, payload_len, is_tcp, src_port, dst_port,
               stage_in, next_len_in, packets_seen, http_excluded,
        input  ready
    );
    modport sink (
        input  valid, data_byte, byte_last, payload_len, is_tcp, src_port, dst_port,
               stage_in, next_len_in, packets_seen, http_excluded,
        output ready
    );
endinterface

interface ipsc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [2:0]  stage_out;
    logic [15:0] next_len_out;

    modport source (output valid, verdict, stage_out, next_len_out, input ready);
    modport sink (input valid, verdict, stage_out, next_len_out, output ready);
endinterface

FILE: design/ipsc_capture.sv
`timescale 1ns / 1ps
// Capture: per-packet byte history and the registered snapshot of a finished packet.
module ipsc_capture (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  ipsc_pkg::item_t item,
    output ipsc_pkg::job_t  job
);
    import ipsc_pkg::*;

    logic [HEAD_DEPTH-1:0][7:0] head_reg, head_next;
    logic [3:0][7:0]            tail_reg, tail_next;
    logic [15:0]                pos_reg, pos_next;
    logic                       zs_reg, zs_next, zl_reg, zl_next;
    job_t                       job_reg;

    always_comb
    begin
        head_next = head_reg;
        if (pos_reg < 16'(HEAD_DEPTH))
        begin
            head_next[pos_reg[4:0]] = item.data_byte;
        end
        tail_next = {tail_reg[2:0], item.data_byte};
        zs_next   = zs_reg && !(item.data_byte != 8'd0 && pos_reg >= 16'd8 && pos_reg <= 16'd81);
        zl_next   = zl_reg && !(item.data_byte != 8'd0 && pos_reg <= 16'd199);
        pos_next  = (pos_reg != 16'hffff) ? pos_reg + 16'd1 : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg <= '0;
            pos_reg  <= '0;
            zs_reg   <= 1'b1;
            zl_reg   <= 1'b1;
        end
        else if (accept)
        begin
            tail_reg <= tail_next;
            // restart the byte count at the end of a packet
            pos_reg  <= item.byte_last ? 16'd0 : pos_next;
            zs_reg   <= item.byte_last ? 1'b1 : zs_next;
            zl_reg   <= item.byte_last ? 1'b1 : zl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_reg <= head_next;
        end
        if (accept && item.byte_last)
        begin
            job_reg.head          <= head_next;
            job_reg.tail          <= tail_next;
            job_reg.zero_short    <= zs_next;
            job_reg.zero_long     <= zl_next;
            job_reg.len           <= item.payload_len;
            job_reg.is_tcp        <= item.is_tcp;
            job_reg.src_port      <= item.src_port;
            job_reg.dst_port      <= item.dst_port;
            job_reg.stage         <= item.stage_in;
            job_reg.next_len      <= item.next_len_in;
            job_reg.seen          <= item.packets_seen;
            job_reg.http_excluded <= item.http_excluded;
        end
    end

    assign job = job_reg;

`ifndef SYNTHESIS
    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.byte_last |=> pos_reg == 16'd0 && zs_reg && zl_reg)
        else $error("position not restarted after last byte");
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !item.byte_last && pos_reg != 16'hffff |=> pos_reg == $past(pos_reg) + 16'd1)
        else $error("position did not advance");
    a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !accept && !zl_reg |=> !zl_reg)
        else $error("long zero flag set without a packet end");
`endif
endmodule

FILE: design/ipsc_rules.sv
`timescale 1ns / 1ps
// Rules: signature evaluation of a captured packet.
module ipsc_rules (
    input  ipsc_pkg::job_t    job,
    input  ipsc_pkg::cfg_t    cfg,
    output ipsc_pkg::result_t result
);
    import ipsc_pkg::*;

    function automatic logic is_ver(input logic [15:0] v);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 46; k++)
        begin
            hit = hit | (v == KNOWN_VERSIONS[k]);
        end
        return hit;
    endfunction

    function automatic logic is_cmd(input logic [15:0] v);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 12; k++)
        begin
            hit = hit | (v == KNOWN_CMDS[k]);
        end
        return hit;
    endfunction

    function automatic logic is_tag(input logic [15:0] v);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < 11; k++)
        begin
            hit = hit | (v == UDP_TAGS[k]);
        end
        return hit;
    endfunction

    function automatic result_t bump(input logic [2:0] st, input logic [15:0] nl);
        result_t r;
        r.stage    = (st != 3'd7) ? st + 3'd1 : st;
        r.verdict  = (r.stage == 3'd3) ? VERDICT_REAL : VERDICT_UNDECIDED;
        r.next_len = nl;
        return r;
    endfunction

    logic [HEAD_DEPTH-1:0][7:0] h;
    logic [15:0] len, w0, w1, w2, w3, w4, w5;
    logic [31:0] d0, d2, d4, d8, d11, d12, tail32;
    logic [7:0]  lb;
    logic        t3, len8, vm_u, vm_t, ft, tag04, udp_hit, tcp_first, tcp_hit;
    logic        f5f, get_hit, mail_hit;

    always_comb
    begin
        h    = job.head;
        len  = job.len;
        lb   = job.tail[0];
        t3   = lb == 8'h03;
        w0   = {h[0], h[1]};
        w1   = {h[1], h[2]};
        w2   = {h[2], h[3]};
        w3   = {h[3], h[4]};
        w4   = {h[4], h[5]};
        w5   = {h[5], h[6]};
        d0   = {h[0], h[1], h[2], h[3]};
        d2   = {h[2], h[3], h[4], h[5]};
        d4   = {h[4], h[5], h[6], h[7]};
        d8   = {h[8], h[9], h[10], h[11]};
        d11  = {h[11], h[12], h[13], h[14]};
        d12  = {h[12], h[13], h[14], h[15]};
        tail32 = job.tail;
        // a one-byte length field matches only short packets
        len8 = (len[15:8] == 8'd0) && (h[4] == len[7:0]);

        vm_u = len >= 16'd9 && h[0] == 8'h02 && t3 && is_ver(w1) && is_cmd(w3);
        vm_t = len >= 16'd9 && w0 == len && h[2] == 8'h02 && t3 && is_ver(w3) && is_cmd(w5);
        ft   = len >= 16'd9 && is_ver(w1) &&
               ((h[0] == 8'h04 && w3 == len && t3) ||
                (h[0] == 8'h00 && len == 16'd84 && lb == 8'h0c));
        tag04 = len > 16'd2 && h[0] == 8'h04 && t3 &&
                ((w1 == 16'h1549 || w1 == 16'h1801 || w1 == 16'h0961) ||
                 (len > 16'd16 && (w1 == 16'h180d || w1 == 16'h096d) &&
                  d12 == 32'h28000000 && w3 == len));

        udp_hit =
            (len == 16'd27 && w0 == 16'h0300 && h[2] == 8'h01) ||
            (len == 16'd84 && ((w0 == 16'h000e && h[2] == 8'h35) ||
                               (w0 == 16'h0015 && h[2] == 8'h01) ||
                               (w0 == 16'h000b && h[2] == 8'h37) ||
                               (w0 == 16'h0015 && h[2] == 8'h49))) ||
            (len > 16'd10 && ((w0 == 16'h000b && h[2] == 8'h37) ||
                              (d0 == 32'h04163a00 && t3 && len8))) ||
            (len > 16'd2 && (h[0] == 8'h02 || h[0] == 8'h04) && t3 && is_tag(w1)) ||
            (len == 16'd84 && (h[0] == 8'h00 || h[0] == 8'h03) && is_tag(w1)) ||
            tag04 ||
            (len > 16'd2 && (h[0] == 8'h06 || h[0] == 8'h02) && w1 == 16'h0100 &&
             (lb == 8'h00 || t3)) ||
            (len > 16'd5 && w0 == 16'h0203 && w2 == len && w4 == 16'h0b0b) ||
            ((job.dst_port == cfg.special_port || job.src_port == cfg.special_port) &&
             len > 16'd3 && w0 == 16'h0202 && w2 == len);

        tcp_first = len == 16'd39 && d0 == 32'h27000000 && w4 == 16'h0014 &&
                    d11 != 32'd0 && job.tail[1] == 8'd0 && job.tail[0] == 8'd0;

        tcp_hit =
            (len > 16'd4 && w0 == len && w2 == 16'h0212 && h[4] == 8'h0b) ||
            (len > 16'd6 && h[0] == 8'h02 && t3 && w1 == len &&
             (w3 == 16'h0605 || w3 == 16'h0608) && h[5] == 8'h00) ||
            (len > 16'd9 && d0 == 32'h04154900 && {h[5], h[4]} == len && t3) ||
            (len > 16'd9 && d0 == 32'h040e3500 && {h[5], h[4]} == len &&
             h[9] == 8'h33 && t3) ||
            (len > 16'd9 && d0 == 32'h040e0215 && {h[5], h[4]} == len &&
             h[9] == 8'h33 && t3) ||
            (len > 16'd6 && d2 == 32'h020d5500 && w0 == len && t3) ||
            (len > 16'd6 && w0 == 16'h0418 && h[2] == 8'h01 && w3 == len && t3) ||
            (len > 16'd6 && w0 == 16'h0411 && h[2] == 8'h31 && w3 == len && t3) ||
            (len > 16'd6 && w0 == len && w2 == 16'h0211 && h[4] == 8'h31 && t3) ||
            (len > 16'd6 && w0 == len && w2 == 16'h0218 && h[4] == 8'h01 && t3) ||
            (len > 16'd10 && d0 == 32'h04163a00 && t3 && len8) ||
            vm_t || ft;

        f5f = len > 16'd5 && t3 &&
              (({1'b0, job.next_len} == {1'b0, len} + 17'd2 && h[0] == 8'h02 &&
                w1 == 16'h0f5f) ||
               (w0 == len && h[2] == 8'h02 && w3 == 16'h0f5f));

        get_hit = len > 16'd100;
        for (int k = 0; k < 14; k++)
        begin
            get_hit = get_hit & (h[k] == GET_PREFIX[13-k]);
        end

        mail_hit = job.stage == 3'd0 &&
            ((len == 16'd82 && d0 == 32'h0000004e && d4 == 32'h01010000 && job.zero_short) ||
             (len == 16'd182 && d0 == 32'h000000b2 && d4 == 32'h01020000 &&
              d8 == 32'h04015151 && d12 == 32'h4d61696c) ||
             (len == 16'd204 && job.zero_long && tail32 == 32'hfbffffff));

        result.stage    = job.stage;
        result.next_len = job.next_len;
        result.verdict  = VERDICT_UNDECIDED;
        if (!job.is_tcp)
        begin
            if ((job.stage <= 3'd3 && udp_hit) || vm_u || ft)
            begin
                result = bump(job.stage, job.next_len);
            end
            else
            begin
                result.verdict = (job.stage != 3'd0 && job.seen <= cfg.grace) ?
                                 VERDICT_UNDECIDED : VERDICT_EXCLUDED;
            end
        end
        else if (tcp_first)
        begin
            if (job.stage == 3'd4)
            begin
                result.verdict = VERDICT_REAL;
            end
            else
            begin
                result.stage = 3'd4;
            end
        end
        else if (tcp_hit)
        begin
            result = bump(job.stage, job.next_len);
        end
        else if (len == 16'd2)
        begin
            result.next_len = w0;
        end
        else if (f5f || tag04)
        begin
            result = bump(job.stage, job.next_len);
        end
        else if (get_hit)
        begin
            result.verdict = VERDICT_CORREL;
        end
        else if (mail_hit)
        begin
            result.verdict = VERDICT_REAL;
        end
        else
        begin
            result.verdict = job.http_excluded ? VERDICT_EXCLUDED : VERDICT_UNDECIDED;
        end
    end
endmodule

FILE: design/im_protocol_signature_classifier_top.sv
`timescale 1ns / 1ps
// Top level: classifier with APB register port, capture, rules and result register.
//
// Payload bytes stream in one transaction per cycle while the input is ready,
// offset zero first. Each byte updates the packet history (first 17 bytes,
// last 4 bytes, position, zero-run flags); the byte marked last also loads a
// packet snapshot register. The rules evaluate that snapshot combinationally
// into the result register; one packet per cycle is sustained while the
// output is not stalled. The input stays ready while a result waits as long
// as the snapshot register can move on; ready drops only when both the
// snapshot and result registers are full and the result is stalled.
// Bytes not marked last never produce a result. Registers: 0x0 special UDP
// port (16 bits, reset 9000), 0x4 grace packet count (8 bits, reset 5); write
// them only while no packet is in flight.
module im_protocol_signature_classifier_top (
    input  logic              clk,
    input  logic              rst_n,
    ipsc_in_if.sink           in_ch,
    ipsc_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ipsc_pkg::*;

    cfg_t    cfg_reg;
    item_t   item;
    job_t    job;
    result_t rule_res, res_reg;
    logic    job_valid_reg, job_valid_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_free, job_adv, in_accept;
    reg_index_t wr_index;

    // APB: no wait states (pready tied high), register chosen by address bit 2
    assign pready   = 1'b1;
    assign wr_index = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.special_port <= SPECIAL_PORT_RESET;
            cfg_reg.grace        <= GRACE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (wr_index)
                REG_SPECIAL_PORT: cfg_reg.special_port <= pwdata[15:0];
                REG_GRACE:        cfg_reg.grace        <= pwdata[7:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (wr_index)
            REG_SPECIAL_PORT: prdata = {16'd0, cfg_reg.special_port};
            REG_GRACE:        prdata = {24'd0, cfg_reg.grace};
            default:          prdata = '0;
        endcase
    end

    // gather the input transaction
    always_comb
    begin
        item.data_byte     = in_ch.data_byte;
        item.byte_last     = in_ch.byte_last;
        item.payload_len   = in_ch.payload_len;
        item.is_tcp        = in_ch.is_tcp;
        item.src_port      = in_ch.src_port;
        item.dst_port      = in_ch.dst_port;
        item.stage_in      = in_ch.stage_in;
        item.next_len_in   = in_ch.next_len_in;
        item.packets_seen  = in_ch.packets_seen;
        item.http_excluded = in_ch.http_excluded;
    end

    // result slot frees when empty or being taken; snapshot advances into it
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign job_adv     = job_valid_reg && out_free;
    assign in_ch.ready = !job_valid_reg || out_free;
    assign in_accept   = in_ch.valid && in_ch.ready;

    ipsc_capture u_capture (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .item   (item),
        .job    (job)
    );

    ipsc_rules u_rules (
        .job    (job),
        .cfg    (cfg_reg),
        .result (rule_res)
    );

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (in_accept && item.byte_last)
        begin
            job_valid_next = 1'b1;
        end
        else if (job_adv)
        begin
            job_valid_next = 1'b0;
        end
        out_valid_next = job_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // load the verdict when the snapshot moves on; hold it otherwise
    always_ff @(posedge clk)
    begin
        if (job_adv)
        begin
            res_reg <= rule_res;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.verdict      = res_reg.verdict;
    assign out_ch.stage_out    = res_reg.stage;
    assign out_ch.next_len_out = res_reg.next_len;

`ifndef SYNTHESIS
    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && !out_free |=> job_valid_reg)
        else $error("packet snapshot dropped while result stalled");
    a_job_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        job_adv |=> out_valid_reg)
        else $error("snapshot advanced without a result");
    a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_ch.byte_last |=> job_valid_reg)
        else $error("last byte did not load a snapshot");
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !job_valid_reg |-> in_ch.ready)
        else $error("input stalled with empty snapshot register");
`endif
endmodule
